// ===== design/ild_pkg.sv =====
// Shared types, constants and opcode flag maps of the x86 length decoder.
`default_nettype none
package ild_pkg;

    localparam int unsigned MAX_INSTR_LEN = 31;
    localparam int unsigned CNT_W         = $clog2(MAX_INSTR_LEN + 1);
    localparam int unsigned LEN_W         = 5;
    localparam int unsigned LEN_MAX       = 31;
    localparam int unsigned COVER_W       = 6;
    localparam int unsigned COVER_MAX     = 63;
    localparam int unsigned MIN_W         = 4;
    localparam int unsigned SUM_W         = ((CNT_W > COVER_W) ? CNT_W : COVER_W) + 1;
    localparam int unsigned TAIL_W        = 4;
    localparam logic [MIN_W-1:0] MIN_COVER_RST = 4'd5;

    localparam logic [15:0] F_P    = 16'h0001;
    localparam logic [15:0] F_66   = 16'h0002;
    localparam logic [15:0] F_67   = 16'h0004;
    localparam logic [15:0] F_D66  = 16'h0008;
    localparam logic [15:0] F_D1   = 16'h0010;
    localparam logic [15:0] F_D2   = 16'h0020;
    localparam logic [15:0] F_D4   = 16'h0040;
    localparam logic [15:0] F_A67  = 16'h0080;
    localparam logic [15:0] F_A1   = 16'h0100;
    localparam logic [15:0] F_A2   = 16'h0200;
    localparam logic [15:0] F_A4   = 16'h0400;
    localparam logic [15:0] F_M    = 16'h0800;
    localparam logic [15:0] F_W    = 16'h1000;
    localparam logic [15:0] F_T    = 16'h2000;
    localparam logic [15:0] F_X    = 16'h4000;
    localparam logic [15:0] F_B    = 16'h8000;
    localparam logic [15:0] F_MOD0 = 16'h2000;

    localparam int unsigned PF_OP16 = 0;
    localparam int unsigned PF_AD16 = 1;
    localparam int unsigned PF_TEST = 2;

    typedef enum logic [2:0] {
        PH_OPC   = 3'd0,
        PH_OP0F  = 3'd1,
        PH_MODRM = 3'd2,
        PH_SIB   = 3'd3,
        PH_TAIL  = 3'd4
    } t_phase;

    typedef struct packed {
        logic [LEN_W-1:0]   instr_len;
        logic               is_error;
        logic [COVER_W-1:0] cover_len;
        logic               cover_done;
    } t_result;

    function automatic logic [15:0] map_one(input logic [7:0] b);
        logic [15:0] t;
        t = '0;
        unique case (b[7:4])
            4'h0, 4'h1, 4'h2, 4'h3: begin
                unique case (b[2:0])
                    3'd0, 3'd1, 3'd2, 3'd3: t = F_M;
                    3'd4, 3'd5:             t = F_W;
                    3'd6:                   t = b[5] ? F_P : 16'h0000;
                    default:                t = (b == 8'h0F) ? F_X : 16'h0000;
                endcase
            end
            4'h6: begin
                unique case (b[3:0])
                    4'h2, 4'h3: t = F_M;
                    4'h4, 4'h5: t = F_P;
                    4'h6:       t = F_P | F_66;
                    4'h7:       t = F_P | F_67;
                    4'h8:       t = F_D66;
                    4'h9:       t = F_M | F_D66;
                    4'hA:       t = F_D1;
                    4'hB:       t = F_M | F_D1;
                    default:    t = '0;
                endcase
            end
            4'h7: t = F_D1;
            4'h8: begin
                unique case (b[3:0])
                    4'h0, 4'h2, 4'h3: t = F_M | F_D1;
                    4'h1:             t = F_M | F_D66;
                    default:          t = F_M;
                endcase
            end
            4'h9: t = (b[3:0] == 4'hA) ? (F_D66 | F_A2) : 16'h0000;
            4'hA: begin
                unique case (b[3:0])
                    4'h0, 4'h1, 4'h2, 4'h3: t = F_A67;
                    4'h8:                   t = F_D1;
                    4'h9:                   t = F_D66;
                    default:                t = '0;
                endcase
            end
            4'hB: t = b[3] ? F_D66 : F_D1;
            4'hC: begin
                unique case (b[3:0])
                    4'h0, 4'h1: t = F_M | F_D1;
                    4'h2, 4'hA: t = F_D2;
                    4'h4, 4'h5: t = F_M;
                    4'h6, 4'h7: t = F_M | F_D66;
                    4'h8:       t = F_D2 | F_D1;
                    4'hD:       t = F_D1 | F_D4;
                    default:    t = '0;
                endcase
            end
            4'hD: t = (b[3:2] == 2'b01) ? 16'h0000 : F_M;
            4'hE: begin
                unique case (b[3:0])
                    4'h8, 4'h9: t = F_D66;
                    4'hA:       t = F_D66 | F_A2;
                    4'hB:       t = F_D1;
                    4'hC, 4'hD, 4'hE, 4'hF: t = '0;
                    default:    t = F_D1;
                endcase
            end
            4'hF: begin
                unique case (b[3:0])
                    4'h0, 4'h2, 4'h3: t = F_P;
                    4'h6, 4'h7:       t = F_T;
                    4'hE, 4'hF:       t = F_M;
                    default:          t = '0;
                endcase
            end
            default: t = '0;
        endcase
        return t;
    endfunction

    function automatic logic [15:0] map_0f(input logic [7:0] b);
        logic [15:0] t;
        t = '0;
        unique case (b[7:4])
            4'h0: begin
                unique case (b[3:0])
                    4'h0, 4'h1, 4'h2, 4'h3:       t = F_M;
                    4'h6, 4'h8, 4'h9, 4'hA, 4'hB: t = '0;
                    default:                      t = F_B;
                endcase
            end
            4'h8: t = F_D66;
            4'h9: t = F_M;
            4'hA: begin
                unique case (b[3:0])
                    4'h0, 4'h1, 4'h2, 4'h8, 4'h9, 4'hA: t = '0;
                    4'h3, 4'h5, 4'hB, 4'hD, 4'hF:       t = F_M;
                    4'h4, 4'hC:                         t = F_M | F_D1;
                    default:                            t = F_B;
                endcase
            end
            4'hB: begin
                unique case (b[3:0])
                    4'h8, 4'h9: t = F_B;
                    4'hA:       t = F_M | F_D1;
                    default:    t = F_M;
                endcase
            end
            4'hC: begin
                unique case (b[3:0])
                    4'h0, 4'h1:                         t = F_M;
                    4'h2, 4'h3, 4'h4, 4'h5, 4'h6, 4'h7: t = F_B;
                    default:                            t = '0;
                endcase
            end
            default: t = F_B;
        endcase
        return t;
    endfunction

endpackage
`default_nettype wire

// ===== design/ild_in_stage.sv =====
// Input register of the length decoder: holds one code byte until it is decoded.
`default_nettype none
module ild_in_stage (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_advance,
    output logic            o_valid,
    output logic [7:0]      o_byte
);
    import ild_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_byte  = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

endmodule
`default_nettype wire

// ===== design/ild_core.sv =====
// Decode state of the length decoder and the per-byte next-state logic.
`default_nettype none
module ild_core (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_step,
    input  wire logic [7:0]                i_byte,
    input  wire logic [ild_pkg::MIN_W-1:0] i_min_cover_len,
    output logic                           o_emit,
    output ild_pkg::t_result               o_result
);
    import ild_pkg::*;

    t_phase               r_phase, n_phase;
    logic [2:0]           r_pfx, n_pfx;
    logic [15:0]          r_pend, n_pend;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [TAIL_W-1:0]    r_tail, n_tail;
    logic [COVER_W-1:0]   r_cover, n_cover;

    logic [CNT_W-1:0]     cnt_inc;
    logic [15:0]          tbl;
    logic [15:0]          fin_flags;
    logic [15:0]          fin_f;
    logic [TAIL_W-1:0]    fin_tail;
    logic                 do_finish;
    logic                 do_end;
    logic                 do_err;
    logic [1:0]           mod;
    logic [2:0]           rm;
    logic [SUM_W-1:0]     cnt_ext;
    logic [SUM_W-1:0]     cover_sum;
    logic [COVER_W-1:0]   cover_sat;
    logic                 cover_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_OPC;
            r_pfx   <= '0;
            r_pend  <= '0;
            r_cnt   <= '0;
            r_tail  <= '0;
            r_cover <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pfx   <= n_pfx;
            r_pend  <= n_pend;
            r_cnt   <= n_cnt;
            r_tail  <= n_tail;
            r_cover <= n_cover;
        end
    end

    always_comb begin
        cnt_inc   = (r_cnt < CNT_W'(MAX_INSTR_LEN)) ? r_cnt + 1'b1 : r_cnt;
        n_phase   = r_phase;
        n_pfx     = r_pfx;
        n_pend    = r_pend;
        n_cnt     = cnt_inc;
        n_tail    = r_tail;
        n_cover   = r_cover;
        tbl       = '0;
        fin_flags = '0;
        do_finish = 1'b0;
        do_end    = 1'b0;
        do_err    = 1'b0;
        mod       = i_byte[7:6];
        rm        = i_byte[2:0];

        unique case (r_phase)
            PH_OP0F: begin
                tbl = map_0f(i_byte);
                if (|(tbl & F_B)) begin
                    do_err = 1'b1;
                end else begin
                    n_pfx = '0;
                    if (|(tbl & F_M)) begin
                        n_pend  = tbl;
                        n_phase = PH_MODRM;
                    end else begin
                        fin_flags = tbl;
                        do_finish = 1'b1;
                    end
                end
            end
            PH_MODRM: begin
                if (r_pfx[PF_TEST]) begin
                    if (|(i_byte & 8'h38)) begin
                        n_pend = n_pend & ~(F_D1 | F_D66);
                    end
                    n_pfx[PF_TEST] = 1'b0;
                end
                do_finish = 1'b1;
                if (mod != 2'b11) begin
                    if (r_pfx[PF_AD16]) begin
                        if (mod == 2'b00 && rm == 3'd6) n_pend = n_pend | F_A2;
                        if (mod == 2'b01)               n_pend = n_pend | F_A1;
                        if (mod == 2'b10)               n_pend = n_pend | F_A2;
                    end else begin
                        if (mod == 2'b01) n_pend = n_pend | F_A1;
                        if (mod == 2'b10) n_pend = n_pend | F_A4;
                        if (rm == 3'd4) begin
                            if (mod == 2'b00) n_pend = n_pend | F_MOD0;
                            n_phase   = PH_SIB;
                            do_finish = 1'b0;
                        end else if (rm == 3'd5 && mod == 2'b00) begin
                            n_pend = n_pend | F_A4;
                        end
                    end
                end
                fin_flags = n_pend;
            end
            PH_SIB: begin
                fin_flags = r_pend & ~F_MOD0;
                if (i_byte[2:0] == 3'd5 && |(r_pend & F_MOD0)) begin
                    fin_flags = fin_flags | F_A4;
                end
                do_finish = 1'b1;
            end
            PH_TAIL: begin
                n_tail = (r_tail != '0) ? r_tail - 1'b1 : r_tail;
                if (n_tail == '0) do_end = 1'b1;
            end
            default: begin
                tbl = map_one(i_byte);
                if (|(tbl & F_P)) begin
                    if (|(tbl & F_66)) n_pfx[PF_OP16] = 1'b1;
                    if (|(tbl & F_67)) n_pfx[PF_AD16] = 1'b1;
                    n_phase = PH_OPC;
                end else if (|(tbl & F_T)) begin
                    n_pfx          = '0;
                    n_pfx[PF_TEST] = 1'b1;
                    n_pend  = F_M | (i_byte[0] ? F_D66 : F_D1);
                    n_phase = PH_MODRM;
                end else if (|(tbl & F_X)) begin
                    n_phase = PH_OP0F;
                end else begin
                    if (|(tbl & F_W)) begin
                        tbl = (tbl & ~F_W) | (i_byte[0] ? F_D66 : F_D1);
                    end
                    if (|(tbl & F_M)) begin
                        n_pend  = tbl;
                        n_phase = PH_MODRM;
                    end else begin
                        fin_flags = tbl;
                        do_finish = 1'b1;
                    end
                end
            end
        endcase

        fin_f = fin_flags;
        if (|(fin_f & F_A67)) fin_f = fin_f | (n_pfx[PF_AD16] ? F_A2 : F_A4);
        if (|(fin_f & F_D66)) fin_f = fin_f | (n_pfx[PF_OP16] ? F_D2 : F_D4);
        fin_tail = ((|(fin_f & F_A1)) ? 4'd1 : 4'd0)
                 + ((|(fin_f & F_A2)) ? 4'd2 : 4'd0)
                 + ((|(fin_f & F_A4)) ? 4'd4 : 4'd0)
                 + ((|(fin_f & F_D1)) ? 4'd1 : 4'd0)
                 + ((|(fin_f & F_D2)) ? 4'd2 : 4'd0)
                 + ((|(fin_f & F_D4)) ? 4'd4 : 4'd0);
        if (do_finish) begin
            if (fin_tail == '0) begin
                do_end = 1'b1;
            end else begin
                n_pend  = fin_f;
                n_tail  = fin_tail;
                n_phase = PH_TAIL;
            end
        end

        cnt_ext   = SUM_W'(cnt_inc);
        cover_sum = SUM_W'(r_cover) + cnt_ext;
        cover_sat = (cover_sum > SUM_W'(COVER_MAX)) ? COVER_W'(COVER_MAX)
                                                     : cover_sum[COVER_W-1:0];
        cover_hit = cover_sat >= COVER_W'(i_min_cover_len);

        o_result.instr_len  = (cnt_ext > SUM_W'(LEN_MAX)) ? LEN_W'(LEN_MAX)
                                                          : cnt_ext[LEN_W-1:0];
        o_result.is_error   = do_err;
        o_result.cover_len  = do_err ? '0 : cover_sat;
        o_result.cover_done = !do_err && cover_hit;

        if (do_end || do_err) begin
            n_phase = PH_OPC;
            n_pfx   = '0;
            n_pend  = '0;
            n_cnt   = '0;
            n_tail  = '0;
            n_cover = (do_err || cover_hit) ? '0 : cover_sat;
        end

        o_emit = i_step && (do_end || do_err);
    end

endmodule
`default_nettype wire

// ===== design/ild_out_stage.sv =====
// Result register of the length decoder: holds one result until it is taken.
`default_nettype none
module ild_out_stage (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  ild_pkg::t_result       i_result,
    input  wire logic              i_take,
    output logic                   o_valid,
    output ild_pkg::t_result       o_result
);
    import ild_pkg::*;

    logic    r_valid;
    t_result r_result;

    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

endmodule
`default_nettype wire

// ===== design/x86_instruction_length_decoder_unit.sv =====
// Top level of the streaming x86 32-bit instruction length decoder.
// Code bytes enter one per item and one per cycle; a byte is decoded against the
// opcode flag maps and the decode state while it sits in the input register, and
// its result, if any, sits in the result register from the next cycle on.
// Throughput is one byte per cycle, set by the single decode step between the
// input and result registers; a result that waits holds the input register and
// the decode state, and input stalls with it. A result comes at the last byte of
// each instruction, or at the byte after 0F when that opcode is invalid.
`default_nettype none
module x86_instruction_length_decoder_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [7:0]                    i_code_byte,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [ild_pkg::LEN_W-1:0]          o_instr_len,
    output logic                               o_is_error,
    output logic [ild_pkg::COVER_W-1:0]        o_cover_len,
    output logic                               o_cover_done,
    input  wire logic                          i_cfg_wr_en,
    input  wire logic [ild_pkg::MIN_W-1:0]     i_cfg_min_cover_len
);
    import ild_pkg::*;

    logic [MIN_W-1:0] r_min;
    logic             in_valid;
    logic [7:0]       in_byte;
    logic             advance;
    logic             emit;
    t_result          core_result;
    t_result          out_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= MIN_COVER_RST;
        end else if (i_cfg_wr_en) begin
            r_min <= i_cfg_min_cover_len;
        end
    end

    assign advance = in_valid && (!o_out_valid || i_out_ready);

    ild_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_byte    (i_code_byte),
        .i_advance (advance),
        .o_valid   (in_valid),
        .o_byte    (in_byte)
    );

    ild_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (advance),
        .i_byte          (in_byte),
        .i_min_cover_len (r_min),
        .o_emit          (emit),
        .o_result        (core_result)
    );

    ild_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (emit),
        .i_result (core_result),
        .i_take   (i_out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_instr_len  = out_result.instr_len;
    assign o_is_error   = out_result.is_error;
    assign o_cover_len  = out_result.cover_len;
    assign o_cover_done = out_result.cover_done;

    a_err_no_cover: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_error |-> o_cover_len == '0 && !o_cover_done)
        else $error("error result carries covered length");

    a_done_reaches_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_cover_done |-> o_cover_len >= COVER_W'(r_min))
        else $error("cover_done below configured minimum");

    a_len_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_instr_len != '0)
        else $error("result with zero instruction length");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && !advance |=> in_valid && $stable(in_byte))
        else $error("input register changed while stalled");

endmodule
`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the streaming x86 instruction length decoder.
`timescale 1ns / 100ps
module testbench;
    import ild_pkg::*;

    localparam logic [15:0] F_NIL = 16'h0000;
    localparam int unsigned PHASE_BYTES = 104;

    typedef struct packed {
        logic [7:0] code;
        logic       typed;
        t_result    res;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_ready;
    logic [7:0]           i_code_byte = 8'h00;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    logic [LEN_W-1:0]     o_instr_len;
    logic                 o_is_error;
    logic [COVER_W-1:0]   o_cover_len;
    logic                 o_cover_done;
    logic                 i_cfg_wr_en = 1'b0;
    logic [MIN_W-1:0]     i_cfg_min_cover_len = '0;

    logic [15:0] one_byte_flags [0:255] = '{
        F_M, F_M, F_M, F_M, F_W, F_W, F_NIL, F_NIL,
        F_M, F_M, F_M, F_M, F_W, F_W, F_NIL, F_X,
        F_M, F_M, F_M, F_M, F_W, F_W, F_NIL, F_NIL,
        F_M, F_M, F_M, F_M, F_W, F_W, F_NIL, F_NIL,
        F_M, F_M, F_M, F_M, F_W, F_W, F_P, F_NIL,
        F_M, F_M, F_M, F_M, F_W, F_W, F_P, F_NIL,
        F_M, F_M, F_M, F_M, F_W, F_W, F_P, F_NIL,
        F_M, F_M, F_M, F_M, F_W, F_W, F_P, F_NIL,
        F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL,
        F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL,
        F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL,
        F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL,
        F_NIL, F_NIL, F_M, F_M, F_P, F_P, F_P | F_66, F_P | F_67,
        F_D66, F_M | F_D66, F_D1, F_M | F_D1, F_NIL, F_NIL, F_NIL, F_NIL,
        F_D1, F_D1, F_D1, F_D1, F_D1, F_D1, F_D1, F_D1,
        F_D1, F_D1, F_D1, F_D1, F_D1, F_D1, F_D1, F_D1,
        F_M | F_D1, F_M | F_D66, F_M | F_D1, F_M | F_D1, F_M, F_M, F_M, F_M,
        F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M,
        F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL,
        F_NIL, F_NIL, F_D66 | F_A2, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL,
        F_A67, F_A67, F_A67, F_A67, F_NIL, F_NIL, F_NIL, F_NIL,
        F_D1, F_D66, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL,
        F_D1, F_D1, F_D1, F_D1, F_D1, F_D1, F_D1, F_D1,
        F_D66, F_D66, F_D66, F_D66, F_D66, F_D66, F_D66, F_D66,
        F_M | F_D1, F_M | F_D1, F_D2, F_NIL, F_M, F_M, F_M | F_D66, F_M | F_D66,
        F_D2 | F_D1, F_NIL, F_D2, F_NIL, F_NIL, F_D1 | F_D4, F_NIL, F_NIL,
        F_M, F_M, F_M, F_M, F_NIL, F_NIL, F_NIL, F_NIL,
        F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M,
        F_D1, F_D1, F_D1, F_D1, F_D1, F_D1, F_D1, F_D1,
        F_D66, F_D66, F_D66 | F_A2, F_D1, F_NIL, F_NIL, F_NIL, F_NIL,
        F_P, F_NIL, F_P, F_P, F_NIL, F_NIL, F_T, F_T,
        F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_M, F_M
    };

    logic [15:0] esc_flags [0:255] = '{
        F_M, F_M, F_M, F_M, F_B, F_B, F_NIL, F_B,
        F_NIL, F_NIL, F_NIL, F_NIL, F_B, F_B, F_B, F_B,
        F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B,
        F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B,
        F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B,
        F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B,
        F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B,
        F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B,
        F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B,
        F_D66, F_D66, F_D66, F_D66, F_D66, F_D66, F_D66, F_D66,
        F_D66, F_D66, F_D66, F_D66, F_D66, F_D66, F_D66, F_D66,
        F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M,
        F_NIL, F_NIL, F_NIL, F_M, F_M | F_D1, F_M, F_B, F_B,
        F_NIL, F_NIL, F_NIL, F_M, F_M | F_D1, F_M, F_B, F_M,
        F_M, F_M, F_M, F_M, F_M, F_M, F_M, F_M,
        F_B, F_B, F_M | F_D1, F_M, F_M, F_M, F_M, F_M,
        F_M, F_M, F_B, F_B, F_B, F_B, F_B, F_B,
        F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL, F_NIL,
        F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B,
        F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B,
        F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B, F_B
    };

    logic [7:0] legacy_prefixes [0:10] = '{
        8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65, 8'h66, 8'h67, 8'hF0, 8'hF2, 8'hF3
    };

    t_row directed_rows [0:24] = '{
        '{8'h90, 1'b1, '{5'd1, 1'b0, 6'd1, 1'b0}},
        '{8'h0F, 1'b0, '0}, '{8'hFF, 1'b1, '{5'd2, 1'b1, 6'd0, 1'b0}},
        '{8'h66, 1'b0, '0}, '{8'hB8, 1'b0, '0}, '{8'h34, 1'b0, '0}, '{8'h12, 1'b0, '0},
        '{8'hF7, 1'b0, '0}, '{8'hC0, 1'b0, '0}, '{8'h11, 1'b0, '0}, '{8'h22, 1'b0, '0},
        '{8'h33, 1'b0, '0}, '{8'h44, 1'b0, '0},
        '{8'hF6, 1'b0, '0}, '{8'hD8, 1'b0, '0},
        '{8'h8B, 1'b0, '0}, '{8'h44, 1'b0, '0}, '{8'h24, 1'b0, '0}, '{8'h08, 1'b0, '0},
        '{8'hCD, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
        '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0}
    };

    t_phase       dec_phase;
    logic [2:0]   pfx;
    logic [15:0]  pend;
    int           nbytes;
    int           tail_cnt;
    int           covered;
    logic [3:0]   min_cover;

    t_result      expected_results [$];
    logic         typed_on = 1'b0;
    t_result      typed_res = '0;
    int unsigned  fail_count = 0;
    int unsigned  bytes_sent = 0;
    int           burst_left = 0;
    int           ready_mode = 0;
    int           ready_cycles = 0;
    int unsigned  ready_step = 0;

    x86_instruction_length_decoder_unit uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_code_byte         (i_code_byte),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_instr_len         (o_instr_len),
        .o_is_error          (o_is_error),
        .o_cover_len         (o_cover_len),
        .o_cover_done        (o_cover_done),
        .i_cfg_wr_en         (i_cfg_wr_en),
        .i_cfg_min_cover_len (i_cfg_min_cover_len)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic void clear_decode_state();
        dec_phase = PH_OPC;
        pfx       = '0;
        pend      = '0;
        nbytes    = 0;
        tail_cnt  = 0;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input int n);
        return LEN_W'((n > int'(LEN_MAX)) ? int'(LEN_MAX) : n);
    endfunction

    function automatic void retire_instr(output bit got, output t_result r);
        int len;
        len = nbytes;
        clear_decode_state();
        covered = (covered + len > int'(COVER_MAX)) ? int'(COVER_MAX) : covered + len;
        r.instr_len  = sat_len(len);
        r.is_error   = 1'b0;
        r.cover_len  = COVER_W'(covered);
        r.cover_done = covered >= int'(min_cover);
        if (r.cover_done) begin
            covered = 0;
        end
        got = 1'b1;
    endfunction

    function automatic void close_instr(output bit got, output t_result r);
        logic [15:0] f;
        int tl;
        f = pend;
        if (f & F_A67) f |= pfx[PF_AD16] ? F_A2 : F_A4;
        if (f & F_D66) f |= pfx[PF_OP16] ? F_D2 : F_D4;
        tl = int'(|(f & F_A1)) + 2 * int'(|(f & F_A2)) + 4 * int'(|(f & F_A4))
           + int'(|(f & F_D1)) + 2 * int'(|(f & F_D2)) + 4 * int'(|(f & F_D4));
        pend = f;
        got = 1'b0;
        r = '0;
        if (tl == 0) begin
            retire_instr(got, r);
        end else begin
            tail_cnt  = tl;
            dec_phase = PH_TAIL;
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, output bit got, output t_result r);
        logic [15:0] t;
        logic [1:0]  md;
        logic [2:0]  rm;
        got = 1'b0;
        r = '0;
        md = b[7:6];
        rm = b[2:0];
        if (nbytes < int'(MAX_INSTR_LEN)) nbytes++;
        case (dec_phase)
            PH_OP0F: begin
                t = esc_flags[b];
                if (t & F_B) begin
                    r = '{sat_len(nbytes), 1'b1, '0, 1'b0};
                    got = 1'b1;
                    clear_decode_state();
                    covered = 0;
                end else begin
                    pend = t;
                    pfx = '0;
                    if (pend & F_M) dec_phase = PH_MODRM;
                    else close_instr(got, r);
                end
            end
            PH_MODRM: begin
                if (pfx[PF_TEST]) begin
                    if (b[5:3] != 3'd0) pend &= ~(F_D1 | F_D66);
                    pfx[PF_TEST] = 1'b0;
                end
                if (md == 2'd3) begin
                    close_instr(got, r);
                end else if (pfx[PF_AD16]) begin
                    if (md == 2'd0 && rm == 3'd6) pend |= F_A2;
                    if (md == 2'd1) pend |= F_A1;
                    if (md == 2'd2) pend |= F_A2;
                    close_instr(got, r);
                end else begin
                    if (md == 2'd1) pend |= F_A1;
                    if (md == 2'd2) pend |= F_A4;
                    if (rm == 3'd4) begin
                        if (md == 2'd0) pend |= F_MOD0;
                        dec_phase = PH_SIB;
                    end else begin
                        if (rm == 3'd5 && md == 2'd0) pend |= F_A4;
                        close_instr(got, r);
                    end
                end
            end
            PH_SIB: begin
                if (rm == 3'd5 && (pend & F_MOD0)) pend |= F_A4;
                pend &= ~F_MOD0;
                close_instr(got, r);
            end
            PH_TAIL: begin
                if (tail_cnt > 0) tail_cnt--;
                if (tail_cnt == 0) retire_instr(got, r);
            end
            default: begin
                t = one_byte_flags[b];
                if (t & F_P) begin
                    if (t & F_66) pfx[PF_OP16] = 1'b1;
                    if (t & F_67) pfx[PF_AD16] = 1'b1;
                end else if (t & F_T) begin
                    pfx = '0;
                    pfx[PF_TEST] = 1'b1;
                    pend = F_M | (b[0] ? F_D66 : F_D1);
                    dec_phase = PH_MODRM;
                end else if (t & F_X) begin
                    dec_phase = PH_OP0F;
                end else begin
                    pend = t;
                    if (t & F_W) pend = (t & ~F_W) | (b[0] ? F_D66 : F_D1);
                    if (pend & F_M) dec_phase = PH_MODRM;
                    else close_instr(got, r);
                end
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        bit got;
        t_result r;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            decode_byte(i_code_byte, got, r);
            if (typed_on) expected_results.push_back(typed_res);
            else if (got) expected_results.push_back(r);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected item: instr_len %0d is_error %0d", o_instr_len, o_is_error);
                fail_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_instr_len !== want.instr_len) begin
                    $error("instr_len: expected %0d, got %0d", want.instr_len, o_instr_len);
                    fail_count++;
                end
                if (o_is_error !== want.is_error) begin
                    $error("is_error: expected %0d, got %0d", want.is_error, o_is_error);
                    fail_count++;
                end
                if (o_cover_len !== want.cover_len) begin
                    $error("cover_len: expected %0d, got %0d", want.cover_len, o_cover_len);
                    fail_count++;
                end
                if (o_cover_done !== want.cover_done) begin
                    $error("cover_done: expected %0d, got %0d", want.cover_done, o_cover_done);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (ready_cycles == 0) begin
            ready_mode   = $urandom_range(0, 3);
            ready_cycles = $urandom_range(20, 120);
        end
        ready_cycles--;
        ready_step++;
        case (ready_mode)
            0:       i_out_ready <= 1'b1;
            1:       i_out_ready <= $urandom_range(0, 3) != 0;
            2:       i_out_ready <= 1'(8'b1101_0110 >> (ready_step % 8));
            default: i_out_ready <= $urandom_range(0, 5) == 0;
        endcase
    end

    task automatic send_byte(input logic [7:0] code);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        i_in_valid  <= 1'b1;
        i_code_byte <= code;
        do @(posedge i_clk); while (!o_in_ready);
        bytes_sent++;
    endtask

    task automatic send_prefix_run(input int n);
        repeat (n) send_byte(legacy_prefixes[$urandom_range(0, 10)]);
    endtask

    task automatic send_instr_shape();
        int pick;
        logic [7:0] c;
        pick = $urandom_range(0, 99);
        c = 8'($urandom);
        if (pick < 2) begin
            send_prefix_run($urandom_range(MAX_INSTR_LEN + 1, MAX_INSTR_LEN + 9));
            send_byte(c);
        end else if (pick < 20) begin
            send_byte(8'h0F);
            if ($urandom_range(0, 4) != 0) begin
                while (esc_flags[c] & F_B) c = 8'($urandom);
            end
            send_byte(c);
        end else if (pick < 32) begin
            send_byte(8'(8'hF6 + $urandom_range(0, 1)));
            if ($urandom_range(0, 1) != 0) c[5:3] = 3'd0;
            send_byte(c);
        end else if (pick < 50) begin
            send_prefix_run($urandom_range(1, 3));
            send_byte(c);
        end else if (pick < 65) begin
            while (!(one_byte_flags[c] & F_M)) c = 8'($urandom);
            send_byte(c);
            c = 8'($urandom);
            c[2:0] = 3'($urandom_range(4, 5));
            send_byte(c);
            c = 8'($urandom);
            if ($urandom_range(0, 1) != 0) c[2:0] = 3'd5;
            send_byte(c);
        end else begin
            send_byte(c);
        end
    endtask

    task automatic set_min_cover(input logic [3:0] v);
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_wr_en         <= 1'b1;
        i_cfg_min_cover_len <= v;
        @(posedge i_clk);
        min_cover = v;
        i_cfg_wr_en <= 1'b0;
    endtask

    initial begin
        logic [3:0] min_plan [0:5];
        int unsigned phase_end;
        clear_decode_state();
        covered   = 0;
        min_cover = MIN_COVER_RST;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[k]) begin
            typed_on  <= directed_rows[k].typed;
            typed_res <= directed_rows[k].res;
            send_byte(directed_rows[k].code);
        end
        typed_on <= 1'b0;
        min_plan = '{4'd0, 4'd15, 4'd1, 4'($urandom_range(2, 14)),
                     4'($urandom_range(1, 15)), MIN_COVER_RST};
        foreach (min_plan[p]) begin
            set_min_cover(min_plan[p]);
            phase_end = bytes_sent + PHASE_BYTES;
            while (bytes_sent < phase_end) send_instr_shape();
        end
        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
